// ===== rtl/mlfq_pkg.sv =====
// Package for the feedback queue scheduler: payload structs, constants and
// state encodings. No dependencies.
`default_nettype none
package mlfq_pkg;
  localparam int unsigned MaxTasks  = 16;
  localparam int unsigned IdW       = 4;
  localparam int unsigned NumLevels = 3;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned SliceW    = 12;
  localparam int unsigned CfgW      = 10;
  localparam int unsigned TaskW     = 11;  // known, level, age
  localparam int unsigned FifoDepth = NumLevels * MaxTasks;
  localparam int unsigned FifoAw    = 6;
  localparam logic [7:0]  AgeMax    = 8'd255;
  localparam logic [1:0]  TopLevel  = 2'd2;

  localparam logic       ModeTick = 1'b0;
  localparam logic       ModeAdd  = 1'b1;
  localparam logic [0:0] RegBaseQuantum = 1'd0;
  localparam logic [0:0] RegAgingLimit  = 1'd1;

  typedef struct packed {
    logic           mode;
    logic [IdW-1:0] task_id;
  } in_t;

  typedef struct packed {
    logic              running_valid;
    logic [IdW-1:0]    running_id;
    logic [1:0]        running_level;
    logic [SliceW-1:0] slice_left;
    logic              add_rejected;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_AGE_RD, S_AGE_WR, S_RM_RD, S_RM_CMP, S_RM_SHIFT,
    S_DSP_RD, S_DSP_SHIFT, S_RUN_RD, S_RUN_WR, S_PUSH, S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/mlfq_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mlfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/mlfq_scheduler_with_aging.sv =====
// Three-level feedback queue scheduler with aging, top level.
// Depends on mlfq_pkg and mlfq_ram.
//
// Usage: in_valid_i/in_ready_o carry one item (mode, task_id); each item
// produces exactly one result on out_valid_o/out_ready_i, the scheduler
// state after the item. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_data_i while the block is idle.
// Steps: an accepted add writes the task row and pushes the id onto level 0
// before its result; a rejected add goes straight to its result. A tick walks
// all 16 task entries through the task memory, then dispatch and the
// running-task update; an expired slice adds a push of the demoted task. A
// dispatch takes the head of the lowest nonempty level and shifts the rest down.
// A promotion searches the old queue (a read and a compare state per entry),
// then the shift moves one entry per cycle; the queue memory has one write and
// one read port.
// Throughput: one item at a time; the next item is taken as soon as the block
// is idle. The result is held until out_ready_i; a stalled receiver holds the
// block in its last step only once a second result is ready.
// Reset: task memory rows carry valid bits cleared at reset, so a task never
// written reads as unknown with level and age zero; queue counts, the running
// task and both configuration registers go to their reset values at once.
// The queue memory is not cleared: only entries below a level's count are used.
`default_nettype none
module mlfq_scheduler_with_aging (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire mlfq_pkg::in_t            in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output mlfq_pkg::out_t                out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [0:0]               cfg_idx_i,
  input  wire logic [mlfq_pkg::CfgW-1:0] cfg_data_i
);
  localparam int unsigned IdW = mlfq_pkg::IdW;
  localparam int unsigned PosW = mlfq_pkg::PosW;
  localparam int unsigned CntW = mlfq_pkg::CntW;
  localparam int unsigned SW = mlfq_pkg::SliceW;
  localparam int unsigned AW = mlfq_pkg::FifoAw;
  localparam int unsigned TW = mlfq_pkg::TaskW;

  mlfq_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [9:0] base_q;
  logic [7:0] limit_q;
  logic [mlfq_pkg::MaxTasks-1:0] row_valid_q, row_valid_d;
  logic [CntW-1:0] cnt_q [mlfq_pkg::NumLevels];
  logic [CntW-1:0] cnt_d [mlfq_pkg::NumLevels];
  logic [IdW-1:0] cur_q, cur_d, idx_q, idx_d, item_id_q, item_id_d;
  logic cur_v_q, cur_v_d, rej_q, rej_d, mode_q, mode_d;
  logic [SW-1:0] slice_q, slice_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [1:0] lvl_q, lvl_d, plvl_q, plvl_d;
  logic [IdW-1:0] pid_q, pid_d;
  logic [1:0] cur_lvl_q, cur_lvl_d;
  logic out_v_q;
  mlfq_pkg::out_t out_q, out_d;
  logic out_load;

  // Task memory: {known, level, age}
  logic t_we;
  logic [IdW-1:0] t_waddr, t_raddr;
  logic [TW-1:0] t_wdata, t_rdata_raw, t_rdata;
  logic t_rvalid_q;
  mlfq_ram #(.Width(TW), .Depth(mlfq_pkg::MaxTasks)) u_task_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata_raw));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_rvalid_q <= 1'b0;
    else t_rvalid_q <= row_valid_q[t_raddr];
  end
  assign t_rdata = t_rvalid_q ? t_rdata_raw : '0;

  // Queue memory: three levels of MaxTasks entries
  logic q_we;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [IdW-1:0] q_wdata, q_rdata;
  mlfq_ram #(.Width(IdW), .Depth(mlfq_pkg::FifoDepth)) u_fifo_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata));

  function automatic logic [AW-1:0] qaddr(logic [1:0] l, logic [CntW-1:0] p);
    return AW'(l) * AW'(mlfq_pkg::MaxTasks) + AW'(p[PosW-1:0]);
  endfunction

  assign in_ready_o  = (state_q == mlfq_pkg::S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlfq_pkg::S_IDLE;
      ret_q <= mlfq_pkg::S_IDLE;
      base_q <= 10'd4;
      limit_q <= 8'd20;
      row_valid_q <= '0;
      for (int i = 0; i < mlfq_pkg::NumLevels; i++) cnt_q[i] <= '0;
      cur_q <= '0;
      cur_v_q <= 1'b0;
      slice_q <= '0;
      cur_lvl_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      row_valid_q <= row_valid_d;
      for (int i = 0; i < mlfq_pkg::NumLevels; i++) cnt_q[i] <= cnt_d[i];
      cur_q <= cur_d;
      cur_v_q <= cur_v_d;
      slice_q <= slice_d;
      cur_lvl_q <= cur_lvl_d;
      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == mlfq_pkg::RegBaseQuantum) base_q <= cfg_data_i;
        else limit_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; item_id_q <= item_id_d; rej_q <= rej_d; mode_q <= mode_d;
    pos_q <= pos_d; lvl_q <= lvl_d; plvl_q <= plvl_d; pid_q <= pid_d;
    if (out_load) out_q <= out_d;
  end

  // Next state
  logic [7:0] age_inc;
  logic [1:0] trow_lvl;
  logic trow_known;
  logic [1:0] first_lvl;
  logic any_ready;
  logic [SW-1:0] new_slice;
  assign trow_known = t_rdata[TW-1];
  assign trow_lvl   = t_rdata[9:8];
  assign age_inc    = (t_rdata[7:0] < mlfq_pkg::AgeMax) ? t_rdata[7:0] + 8'd1 : t_rdata[7:0];
  always_comb begin
    first_lvl = 2'd0;
    any_ready = 1'b1;
    if (cnt_q[0] != '0) first_lvl = 2'd0;
    else if (cnt_q[1] != '0) first_lvl = 2'd1;
    else if (cnt_q[2] != '0) first_lvl = 2'd2;
    else any_ready = 1'b0;
  end
  assign new_slice = SW'({2'b00, base_q} << first_lvl);

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    row_valid_d = row_valid_q;
    for (int i = 0; i < mlfq_pkg::NumLevels; i++) cnt_d[i] = cnt_q[i];
    cur_d = cur_q; cur_v_d = cur_v_q; slice_d = slice_q; cur_lvl_d = cur_lvl_q;
    idx_d = idx_q; item_id_d = item_id_q; rej_d = rej_q; mode_d = mode_q;
    pos_d = pos_q; lvl_d = lvl_q; plvl_d = plvl_q; pid_d = pid_q;
    t_we = 1'b0; t_waddr = idx_q; t_wdata = '0; t_raddr = idx_q;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
    out_load = 1'b0;
    case (state_q)
      mlfq_pkg::S_IDLE: begin
        t_raddr = in_data_i.task_id;
        if (in_valid_i && in_ready_o) begin
          mode_d = in_data_i.mode;
          item_id_d = in_data_i.task_id;
          rej_d = 1'b0;
          idx_d = '0;
          if (in_data_i.mode == mlfq_pkg::ModeAdd) state_d = mlfq_pkg::S_ADD;
          else begin
            t_raddr = '0;
            state_d = mlfq_pkg::S_AGE_WR;
          end
        end
      end
      mlfq_pkg::S_ADD: begin
        if (trow_known) begin
          rej_d = 1'b1;
          state_d = mlfq_pkg::S_DONE;
        end else begin
          t_we = 1'b1; t_waddr = item_id_q; t_wdata = {1'b1, 2'd0, 8'd0};
          row_valid_d[item_id_q] = 1'b1;
          plvl_d = 2'd0; pid_d = item_id_q;
          ret_d = mlfq_pkg::S_DONE;
          state_d = mlfq_pkg::S_PUSH;
        end
      end
      mlfq_pkg::S_AGE_RD: begin
        t_raddr = idx_q;
        state_d = mlfq_pkg::S_AGE_WR;
      end
      mlfq_pkg::S_AGE_WR: begin
        state_d = mlfq_pkg::S_AGE_RD;
        if (trow_known) begin
          t_we = 1'b1; t_waddr = idx_q;
          t_wdata = {1'b1, trow_lvl, age_inc};
          if (!(cur_v_q && cur_q == idx_q) && age_inc >= limit_q && trow_lvl != 2'd0) begin
            t_wdata = {1'b1, trow_lvl - 2'd1, 8'd0};
            lvl_d = trow_lvl; pos_d = '0;
            plvl_d = trow_lvl - 2'd1; pid_d = idx_q;
            state_d = mlfq_pkg::S_RM_RD;
          end
        end
        idx_d = idx_q + 1'b1;
        if (state_d == mlfq_pkg::S_AGE_RD && idx_q == IdW'(mlfq_pkg::MaxTasks - 1))
          state_d = mlfq_pkg::S_DSP_RD;
        ret_d = (idx_q == IdW'(mlfq_pkg::MaxTasks - 1)) ? mlfq_pkg::S_DSP_RD
                                                          : mlfq_pkg::S_AGE_RD;
      end
      // Search the old level for the promoted id, then shift the tail down.
      mlfq_pkg::S_RM_RD: begin
        q_raddr = qaddr(lvl_q, pos_q);
        state_d = (pos_q < cnt_q[lvl_q]) ? mlfq_pkg::S_RM_CMP : mlfq_pkg::S_PUSH;
      end
      mlfq_pkg::S_RM_CMP: begin
        pos_d = pos_q + 1'b1;
        state_d = (q_rdata == pid_q) ? mlfq_pkg::S_RM_SHIFT : mlfq_pkg::S_RM_RD;
        q_raddr = qaddr(lvl_q, pos_q + 1'b1);
      end
      mlfq_pkg::S_RM_SHIFT: begin
        // pos_q points one past the hole; q_rdata holds entry pos_q.
        if (pos_q < cnt_q[lvl_q]) begin
          q_we = 1'b1; q_waddr = qaddr(lvl_q, pos_q - 1'b1); q_wdata = q_rdata;
          pos_d = pos_q + 1'b1;
          q_raddr = qaddr(lvl_q, pos_q + 1'b1);
        end else begin
          cnt_d[lvl_q] = cnt_q[lvl_q] - 1'b1;
          state_d = (ret_q == mlfq_pkg::S_RUN_RD) ? mlfq_pkg::S_RUN_RD : mlfq_pkg::S_PUSH;
        end
      end
      mlfq_pkg::S_DSP_RD: begin
        if (!cur_v_q && any_ready) begin
          q_raddr = qaddr(first_lvl, '0);
          lvl_d = first_lvl; pos_d = '0;
          slice_d = new_slice;
          cur_lvl_d = first_lvl;
          cur_v_d = 1'b1;
          ret_d = mlfq_pkg::S_RUN_RD;
          state_d = mlfq_pkg::S_DSP_SHIFT;
        end else if (cur_v_q) state_d = mlfq_pkg::S_RUN_RD;
        else state_d = mlfq_pkg::S_DONE;
      end
      mlfq_pkg::S_DSP_SHIFT: begin
        cur_d = q_rdata;
        pos_d = 5'd1;
        q_raddr = qaddr(lvl_q, 5'd1);
        state_d = mlfq_pkg::S_RM_SHIFT;
      end
      mlfq_pkg::S_RUN_RD: begin
        if (slice_q != '0) slice_d = slice_q - 1'b1;
        if (slice_q <= SW'(1)) begin
          t_we = 1'b1; t_waddr = cur_q;
          plvl_d = (cur_lvl_q < mlfq_pkg::TopLevel) ? cur_lvl_q + 2'd1 : cur_lvl_q;
          t_wdata = {1'b1, plvl_d, 8'd0};
          cur_lvl_d = plvl_d;
          pid_d = cur_q;
          cur_v_d = 1'b0;
          ret_d = mlfq_pkg::S_DONE;
          state_d = mlfq_pkg::S_PUSH;
        end else begin
          t_we = 1'b1; t_waddr = cur_q; t_wdata = {1'b1, cur_lvl_q, 8'd0};
          state_d = mlfq_pkg::S_DONE;
        end
      end
      mlfq_pkg::S_PUSH: begin
        if (cnt_q[plvl_q] < CntW'(mlfq_pkg::MaxTasks)) begin
          q_we = 1'b1; q_waddr = qaddr(plvl_q, cnt_q[plvl_q]); q_wdata = pid_q;
          cnt_d[plvl_q] = cnt_q[plvl_q] + 1'b1;
        end
        state_d = ret_q;
        if (ret_q == mlfq_pkg::S_AGE_RD) t_raddr = idx_q;
        if (ret_q == mlfq_pkg::S_AGE_RD) state_d = mlfq_pkg::S_AGE_WR;
      end
      mlfq_pkg::S_DONE: begin
        // Hold here while the previous result still waits for the receiver.
        if (!out_v_q || out_ready_i) begin
          out_load = 1'b1;
          state_d = mlfq_pkg::S_IDLE;
        end
      end
      default: state_d = mlfq_pkg::S_IDLE;
    endcase
  end

  // Result: snapshot of running task after the item, plus the add-rejected flag.
  always_comb begin
    out_d = '0;
    out_d.add_rejected = rej_q;
    if (cur_v_q) begin
      out_d.running_valid = 1'b1;
      out_d.running_id = cur_q;
      out_d.running_level = cur_lvl_q;
      out_d.slice_left = slice_q;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == mlfq_pkg::S_IDLE) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_v_q || out_ready_i)) else $error("result overwritten");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CntW'(mlfq_pkg::MaxTasks) && cnt_q[1] <= CntW'(mlfq_pkg::MaxTasks)
    && cnt_q[2] <= CntW'(mlfq_pkg::MaxTasks)) else $error("queue count overflow");
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> cur_lvl_q <= mlfq_pkg::TopLevel) else $error("bad running level");
endmodule
`default_nettype wire

// ===== sim/mlfq_scheduler_with_aging_tb.sv =====
// Testbench for the three-level feedback queue scheduler with aging.
// Depends on mlfq_pkg and the scheduler RTL; runs directed and random phases.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_scheduler_with_aging_tb;
  import mlfq_pkg::*;

  localparam int HalfPeriod = 1;
  localparam int DrainCycles = 400;  // a tick can walk every task and shift queues

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = RegBaseQuantum;
  logic [CfgW-1:0] cfg_data_i = '0;

  always #HalfPeriod clk_i = ~clk_i;

  mlfq_scheduler_with_aging dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Scheduler shadow: the state the block should hold after each transfer.
  logic [9:0] quantum_m;
  logic [7:0] age_limit_m;
  logic known_m [MaxTasks];
  logic [1:0] level_m [MaxTasks];
  logic [7:0] age_m [MaxTasks];
  logic [3:0] ready_q [NumLevels][$];
  logic [3:0] cur_id_m;
  logic cur_valid_m;
  logic [11:0] slice_m;

  out_t expected_state_q [$];
  int mismatches = 0;
  int results_seen = 0;
  int adds_sent = 0;
  int ticks_sent = 0;

  // Traffic shaping, changed per phase.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_cycles = 0;

  function automatic void shadow_push(int lvl, logic [3:0] id);
    if (ready_q[lvl].size() < MaxTasks) ready_q[lvl].push_back(id);
  endfunction

  function automatic void shadow_tick();
    int lvl;
    for (int id = 0; id < MaxTasks; id++) begin
      if (!known_m[id]) continue;
      if (age_m[id] < AgeMax) age_m[id]++;
      if (cur_valid_m && cur_id_m == id) continue;
      // promote a waiting task: pull it out of its old queue, no duplicate
      if (age_m[id] >= age_limit_m && level_m[id] > 0) begin
        for (int i = 0; i < ready_q[level_m[id]].size(); i++) begin
          if (ready_q[level_m[id]][i] == id) begin
            ready_q[level_m[id]].delete(i);
            break;
          end
        end
        level_m[id]--;
        age_m[id] = 0;
        shadow_push(level_m[id], id);
      end
    end
    if (!cur_valid_m) begin
      lvl = 0;
      while (lvl < NumLevels && ready_q[lvl].size() == 0) lvl++;
      if (lvl >= NumLevels) return;
      cur_id_m = ready_q[lvl].pop_front();
      cur_valid_m = 1'b1;
      slice_m = 12'((32'(quantum_m) << lvl) & 32'hFFF);
    end
    if (slice_m > 0) slice_m--;
    age_m[cur_id_m] = 0;
    // expired slice: demote (floor at the top level) and requeue
    if (slice_m == 0) begin
      if (level_m[cur_id_m] < TopLevel) level_m[cur_id_m]++;
      shadow_push(level_m[cur_id_m], cur_id_m);
      cur_valid_m = 1'b0;
    end
  endfunction

  function automatic out_t schedule_step(in_t item);
    out_t res;
    res = '0;
    if (item.mode == ModeAdd) begin
      if (known_m[item.task_id]) begin
        res.add_rejected = 1'b1;
      end else begin
        known_m[item.task_id] = 1'b1;
        level_m[item.task_id] = 0;
        age_m[item.task_id] = 0;
        shadow_push(0, item.task_id);
      end
    end else begin
      shadow_tick();
    end
    if (cur_valid_m) begin
      res.running_valid = 1'b1;
      res.running_id = cur_id_m;
      res.running_level = level_m[cur_id_m];
      res.slice_left = slice_m;
    end
    return res;
  endfunction

  // Receiver ready: a pending hold-off wins over random stalls.
  always @(negedge clk_i) begin
    if (holdoff_cycles > 0) begin
      out_ready_i <= 1'b0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_state_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        exp_r = expected_state_q.pop_front();
        if (out_data_o.running_valid !== exp_r.running_valid) begin
          mismatches++;
          $display("%0t: running_valid exp %0d got %0d", $time,
                   exp_r.running_valid, out_data_o.running_valid);
        end
        if (out_data_o.running_id !== exp_r.running_id) begin
          mismatches++;
          $display("%0t: running_id exp %0d got %0d", $time,
                   exp_r.running_id, out_data_o.running_id);
        end
        if (out_data_o.running_level !== exp_r.running_level) begin
          mismatches++;
          $display("%0t: running_level exp %0d got %0d", $time,
                   exp_r.running_level, out_data_o.running_level);
        end
        if (out_data_o.slice_left !== exp_r.slice_left) begin
          mismatches++;
          $display("%0t: slice_left exp %0d got %0d", $time,
                   exp_r.slice_left, out_data_o.slice_left);
        end
        if (out_data_o.add_rejected !== exp_r.add_rejected) begin
          mismatches++;
          $display("%0t: add_rejected exp %0d got %0d", $time,
                   exp_r.add_rejected, out_data_o.add_rejected);
        end
      end
    end
  end

  // Offer one item; predict its result on the transfer edge.
  task automatic send_item(logic mode, logic [3:0] id);
    in_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    item.mode = mode;
    item.task_id = id;
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (!in_ready_o);
    expected_state_q.push_back(schedule_step(item));
    if (mode == ModeAdd) adds_sent++;
    else ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_state_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write a register while idle and mirror it in the shadow.
  task automatic write_cfg(logic [0:0] idx, logic [CfgW-1:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegBaseQuantum) quantum_m = val;
    else age_limit_m = val[7:0];
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(ModeTick, 4'($urandom));
  endtask

  // Extremes of the fields, duplicate adds, empty ticks, zero quantum and limit.
  task automatic test_directed();
    ticks(2);                       // empty queues: no task to age or run
    send_item(ModeAdd, 4'd0);
    send_item(ModeAdd, 4'd15);
    send_item(ModeAdd, 4'd0);       // duplicate
    ticks(6);                       // slice of 4 runs out, demotion
    write_cfg(RegBaseQuantum, 10'd0);
    ticks(3);                       // zero slice expires on dispatch
    write_cfg(RegAgingLimit, 10'd0);
    send_item(ModeAdd, 4'd10);
    ticks(4);                       // promotion every tick
    write_cfg(RegBaseQuantum, 10'd1023);
    write_cfg(RegAgingLimit, 10'd255);
    ticks(5);                       // largest slice
  endtask

  task automatic test_random(int n, int add_pct);
    repeat (n) begin
      if ($urandom_range(99) < add_pct) send_item(ModeAdd, 4'($urandom));
      else send_item(ModeTick, 4'($urandom));
    end
  endtask

  // Hold the receiver off long enough to fill the result path.
  task automatic test_backpressure();
    holdoff_cycles = 300;
    test_random(20, 30);
    drain();
  endtask

  task automatic run_phase(int q, int lim, int idle, int stall, int n);
    write_cfg(RegBaseQuantum, CfgW'(q));
    write_cfg(RegAgingLimit, CfgW'(lim));
    send_idle_pct = idle;
    stall_pct = stall;
    test_random(n, 10);
  endtask

  initial begin
    quantum_m = 10'd4;
    age_limit_m = 8'd20;
    for (int i = 0; i < MaxTasks; i++) begin
      known_m[i] = 0;
      level_m[i] = 0;
      age_m[i] = 0;
    end
    cur_id_m = 0;
    cur_valid_m = 0;
    slice_m = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    run_phase(4, 20, 0, 0, 250);
    run_phase(1, 1, 80, 0, 200);
    run_phase(1023, 255, 0, 80, 350);   // ages saturate while one task runs
    run_phase(0, 0, 9, 9, 150);
    run_phase(3, 5, 80, 80, 200);
    run_phase(2, 3, 0, 0, 200);
    test_backpressure();
    run_phase(7, 2, 9, 9, 150);
    drain();

    $display("covered %0d adds and %0d ticks, %0d results checked", adds_sent,
             ticks_sent, results_seen);
    $display("quantum 0..1023, aging limit 0..255, idle and stall phases, hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
